// ===== sv/rws_pkg.sv =====
// Shared constants, types and helpers for the roulette wheel selector.
package rws_pkg;

    localparam int POP_MAX_DEF   = 256;
    localparam int RAND_BITS_DEF = 31;

    localparam int SCORE_W    = 25;
    localparam int SCORE_FRAC = 16;
    localparam int RV_W       = 31;
    localparam int POP_W      = 9;
    localparam int IDX_W      = 8;

    localparam logic [POP_W-1:0] POP_RESET = 9'd100;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_ACC   = 6'b000100,
        ST_RADDR = 6'b001000,
        ST_CMP   = 6'b010000,
        ST_OUT   = 6'b100000
    } rws_state_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== sv/rws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rws_ram
    import rws_pkg::*;
#(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rws_sub.sv =====
// Shared subtract-and-compare unit used by both the divider and the search.
module rws_sub
    import rws_pkg::*;
#(
    parameter int W = 32
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         borrow
);

    logic [W:0] full;

    // Borrow is set exactly when a is less than b.
    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[W-1:0];
    assign borrow = full[W];

endmodule

// ===== sv/roulette_wheel_selector_core.sv =====
// Top level of the roulette wheel selector: sequencer, wheel table and result register.
//
// Fitness-proportional selection engine. A load transaction (s_action = 0) adds
// floor(score * TOTAL_MAX / (pop_count * 65536)) to a running total that saturates at
// TOTAL_MAX (the largest random value, all ones over RAND_BITS bits) and stores the
// total in the next table slot; s_first = 1 restarts the wheel at slot zero. A draw
// transaction (s_action = 1) binary-searches the table for the first slot whose
// cumulative value is at least s_random_value, the last slot always counting as
// TOTAL_MAX, and returns its index on the m_ channel. Loads return nothing.
// The block handles one transaction at a time and drops s_ready while it works. In a
// load, a restoring divider produces one quotient bit per cycle through the shared
// subtractor, followed by an accumulate-and-write step (ST_ACC). A draw binary-searches
// over n, the effective population: every search step has a registered table read
// (ST_RADDR) and a compare (ST_CMP), and some values finish in fewer steps than others.
// The result register lets the next transaction start while a finished selection waits
// for m_ready; a second draw that finishes while the earlier selection still waits
// holds in ST_OUT until the register frees up.
// pop_count below 2 acts as 2 and above POP_MAX acts as POP_MAX; write it only while
// the block is idle. Table slots hold no reset value, so draw only over loaded entries.
module roulette_wheel_selector_core
    import rws_pkg::*;
#(
    parameter int POP_MAX   = POP_MAX_DEF,
    parameter int RAND_BITS = RAND_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [POP_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic                 s_first,
    input  logic [SCORE_W-1:0]   s_score,
    input  logic [RV_W-1:0]      s_random_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_W-1:0]     m_selected_index
);

    localparam int CNT_W  = $clog2(POP_MAX + 1);
    localparam int AW     = $clog2(POP_MAX);
    localparam int PROD_W = SCORE_W + RAND_BITS;
    localparam int NUM_W  = PROD_W - SCORE_FRAC;
    localparam int SUB_W  = imax(imax(RAND_BITS, RV_W), CNT_W + 1);
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam int EXT_W  = imax(POP_W, CNT_W);

    localparam logic [RAND_BITS-1:0] TOTAL_MAX = {RAND_BITS{1'b1}};

    // Control state.
    rws_state_t          state_reg, state_next;
    logic [POP_W-1:0]    pop_count_reg;
    logic [RAND_BITS-1:0] total_reg, total_next;
    logic [CNT_W-1:0]    load_cnt_reg, load_cnt_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                m_valid_reg, m_valid_next;

    // Working registers.
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [RV_W-1:0]     rv_reg, rv_next;
    logic [CNT_W-1:0]    pick_reg, pick_next;
    logic [IDX_W-1:0]    m_idx_reg, m_idx_next;

    // Effective population after clamping.
    logic [EXT_W-1:0]    pop_ext;
    logic [EXT_W-1:0]    n_wide;
    logic [CNT_W-1:0]    n_eff;

    // Score scaling: score * TOTAL_MAX with the fraction bits dropped.
    logic [PROD_W-1:0]   prod;
    logic [NUM_W-1:0]    numer;

    // Shared subtractor.
    logic [SUB_W-1:0]    sub_a, sub_b, sub_diff;
    logic                sub_borrow;

    // Divider step.
    logic [CNT_W:0]      div_a;

    // Accumulate step.
    logic                share_sat;
    logic [RAND_BITS:0]  acc_sum;
    logic [RAND_BITS-1:0] acc_total;

    // Search step.
    logic [CNT_W-1:0]    half, mid;
    logic [CNT_W:0]      mid_plus;
    logic                mid_last;
    logic [RAND_BITS-1:0] slot_val;
    logic [CNT_W-1:0]    srch_lo, srch_count, srch_pick;
    logic [CNT_W+IDX_W-1:0] pick_ext;

    // Table port.
    logic                ram_we;
    logic [RAND_BITS-1:0] ram_rdata;

    logic                s_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_selected_index = m_idx_reg;

    always_comb begin
        pop_ext = EXT_W'(pop_count_reg);
        if (pop_ext < EXT_W'(2)) begin
            n_wide = EXT_W'(2);
        end else if (pop_ext > EXT_W'(POP_MAX)) begin
            n_wide = EXT_W'(POP_MAX);
        end else begin
            n_wide = pop_ext;
        end
        n_eff = n_wide[CNT_W-1:0];
    end

    // TOTAL_MAX is all ones, so the product is a shift and a subtract.
    assign prod  = (PROD_W'(s_score) << RAND_BITS) - PROD_W'(s_score);
    assign numer = prod[PROD_W-1:SCORE_FRAC];

    // Binary search address.
    assign half     = count_reg >> 1;
    assign mid      = lo_reg + half;
    assign mid_plus = {1'b0, mid} + (CNT_W + 1)'(1);
    assign mid_last = (mid_plus >= {1'b0, n_eff});
    assign slot_val = mid_last ? TOTAL_MAX : ram_rdata;

    assign div_a = {rem_reg, quo_reg[NUM_W-1]};

    // The subtractor serves the divider in ST_DIV and the slot compare in ST_CMP.
    always_comb begin
        if (state_reg == ST_DIV) begin
            sub_a = SUB_W'(div_a);
            sub_b = SUB_W'(n_eff);
        end else begin
            sub_a = SUB_W'(slot_val);
            sub_b = SUB_W'(rv_reg);
        end
    end

    rws_sub #(
        .W (SUB_W)
    ) u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    // A share beyond RAND_BITS bits saturates the total by itself.
    assign share_sat = |quo_reg[NUM_W-1:RAND_BITS];
    assign acc_sum   = {1'b0, total_reg} + {1'b0, quo_reg[RAND_BITS-1:0]};
    assign acc_total = (share_sat || acc_sum[RAND_BITS]) ? TOTAL_MAX : acc_sum[RAND_BITS-1:0];

    assign ram_we = (state_reg == ST_ACC) && (load_cnt_reg < CNT_W'(POP_MAX));

    rws_ram #(
        .WIDTH (RAND_BITS),
        .DEPTH (POP_MAX)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (load_cnt_reg[AW-1:0]),
        .wdata (acc_total),
        .raddr (mid[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Search update: a slot below the draw value moves the window past mid.
    always_comb begin
        if (sub_borrow) begin
            srch_lo    = mid + CNT_W'(1);
            srch_count = count_reg - half - CNT_W'(1);
        end else begin
            srch_lo    = lo_reg;
            srch_count = half;
        end
        srch_pick = (srch_lo >= n_eff) ? (n_eff - CNT_W'(1)) : srch_lo;
    end

    assign pick_ext = {{IDX_W{1'b0}}, pick_reg};

    always_comb begin
        state_next    = state_reg;
        total_next    = total_reg;
        load_cnt_next = load_cnt_reg;
        dcnt_next     = dcnt_reg;
        m_valid_next  = m_valid_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        lo_next       = lo_reg;
        count_next    = count_reg;
        rv_next       = rv_reg;
        pick_next     = pick_reg;
        m_idx_next    = m_idx_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_action == ACT_LOAD) begin
                        if (s_first) begin
                            total_next    = '0;
                            load_cnt_next = '0;
                        end
                        quo_next   = numer;
                        rem_next   = '0;
                        dcnt_next  = DCNT_W'(NUM_W);
                        state_next = ST_DIV;
                    end else begin
                        lo_next    = '0;
                        count_next = n_eff;
                        rv_next    = s_random_value;
                        state_next = ST_RADDR;
                    end
                end
            end
            ST_DIV: begin
                if (!sub_borrow) begin
                    rem_next = sub_diff[CNT_W-1:0];
                end else begin
                    rem_next = div_a[CNT_W-1:0];
                end
                quo_next  = {quo_reg[NUM_W-2:0], !sub_borrow};
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(1)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                total_next = acc_total;
                if (ram_we) begin
                    load_cnt_next = load_cnt_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end
            ST_RADDR: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                lo_next    = srch_lo;
                count_next = srch_count;
                if (srch_count == '0) begin
                    pick_next  = srch_pick;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_RADDR;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_idx_next   = pick_ext[IDX_W-1:0];
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pop_count_reg <= POP_RESET;
            total_reg     <= '0;
            load_cnt_reg  <= '0;
            dcnt_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_we) begin
                pop_count_reg <= cfg_wdata;
            end
            total_reg     <= total_next;
            load_cnt_reg  <= load_cnt_next;
            dcnt_reg      <= dcnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        lo_reg    <= lo_next;
        count_reg <= count_next;
        rv_reg    <= rv_next;
        pick_reg  <= pick_next;
        m_idx_reg <= m_idx_next;
    end

endmodule

// ===== sv/rws_checker.sv =====
// Port-level checker for the roulette wheel selector and its bind statement.
module rws_checker
    import rws_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_action,
    input logic             m_valid,
    input logic             m_ready,
    input logic [IDX_W-1:0] m_selected_index
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_selected_index))
        else $error("result changed or vanished while stalled");

    // The block drops s_ready after accepting a transaction.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted transaction");

    // A load never produces a result.
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == ACT_LOAD) |=> !$rose(m_valid))
        else $error("result appeared after a load");

    // A new result only comes out of a draw in progress.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while the block was idle");

    // Reset empties the result register.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind roulette_wheel_selector_core rws_checker u_rws_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_action         (s_action),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_selected_index (m_selected_index)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the roulette wheel selector core.
module tb;
    import rws_pkg::*;

    // Largest random value and largest legal score (1.0 is 65536 in Q9.16).
    localparam bit [63:0]          RAND_TOP  = (64'd1 << RAND_BITS_DEF) - 64'd1;
    localparam logic [RV_W-1:0]    RV_TOP    = '1;
    localparam logic [SCORE_W-1:0] SCORE_TOP = 25'h1000000;
    localparam logic [SCORE_W-1:0] SCORE_ONE = 25'h0010000;

    // Settling margin so that a load still in flight can finish.
    localparam int unsigned SETTLE_CYCLES  = 48;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned ITEM_TARGET    = 1830;
    localparam int unsigned REPORT_LIMIT   = 10;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // Tracks the wheel the block should have built and the selections it owes.
    class wheel_scoreboard_t;
        bit [RV_W-1:0]  wheel [POP_MAX_DEF];
        bit             slot_loaded [POP_MAX_DEF];
        bit [63:0]      running_sum;
        int unsigned    fill_count;
        bit [POP_W-1:0] pop_reg;
        bit [IDX_W-1:0] pending_picks [$];
        int unsigned    mismatches;

        function new();
            foreach (slot_loaded[i]) begin
                slot_loaded[i] = 1'b0;
                wheel[i] = '0;
            end
            running_sum = '0;
            fill_count = 0;
            pop_reg = POP_RESET;
            mismatches = 0;
        endfunction

        function void set_pop(input bit [POP_W-1:0] value);
            pop_reg = value;
        endfunction

        // Population after clamping into the supported range.
        function int unsigned wheel_size();
            if (pop_reg < 2) return 2;
            if (pop_reg > POP_MAX_DEF) return POP_MAX_DEF;
            return pop_reg;
        endfunction

        // The last slot of the active wheel always covers the full range.
        function bit [RV_W-1:0] slot_bound(input int unsigned slot, input int unsigned n);
            if (slot + 1 >= n) return RV_TOP;
            return wheel[slot];
        endfunction

        // A draw may only look at slots that were written since reset.
        function bit draw_allowed();
            for (int unsigned i = 0; i + 1 < wheel_size(); i++) begin
                if (!slot_loaded[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit [IDX_W-1:0] predict_pick(input bit [RV_W-1:0] rv);
            int unsigned n;
            int unsigned lo;
            int unsigned span;
            int unsigned half;
            int unsigned mid;
            n = wheel_size();
            lo = 0;
            span = n;
            while (span > 0) begin
                half = span / 2;
                mid = lo + half;
                if (slot_bound(mid, n) < rv) begin
                    lo = mid + 1;
                    span -= half + 1;
                end else begin
                    span = half;
                end
            end
            if (lo >= n) lo = n - 1;
            return lo[IDX_W-1:0];
        endfunction

        function void note_transaction(input logic act, input logic first,
                                       input logic [SCORE_W-1:0] score,
                                       input logic [RV_W-1:0] rv);
            bit [63:0] share;
            bit [63:0] sum;
            if (act == ACT_DRAW) begin
                pending_picks.insert(pending_picks.size(), predict_pick(rv));
                return;
            end
            if (first) begin
                running_sum = '0;
                fill_count = 0;
            end
            share = (64'(score) * RAND_TOP) / (64'(wheel_size()) << SCORE_FRAC);
            sum = running_sum + share;
            if (sum > RAND_TOP) sum = RAND_TOP;
            running_sum = sum;
            // Past the end of the table the total still moves but nothing is stored.
            if (fill_count < POP_MAX_DEF) begin
                wheel[fill_count] = sum[RV_W-1:0];
                slot_loaded[fill_count] = 1'b1;
                fill_count++;
            end
        endfunction

        function void check_selection(input logic [IDX_W-1:0] got);
            bit [IDX_W-1:0] want;
            if (pending_picks.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected selection %0d with no draw outstanding", got);
                return;
            end
            want = pending_picks.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("selected_index mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [POP_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_action = ACT_LOAD;
    logic                 s_first = 1'b0;
    logic [SCORE_W-1:0]   s_score = '0;
    logic [RV_W-1:0]      s_random_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [IDX_W-1:0]     m_selected_index;

    wheel_scoreboard_t sb;
    int unsigned     src_gap_pct = 0;
    int unsigned     sink_stall_pct = 0;
    int unsigned     items_sent = 0;
    int unsigned     quiet_cycles = 0;

    roulette_wheel_selector_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_first          (s_first),
        .s_score          (s_score),
        .s_random_value   (s_random_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_selected_index (m_selected_index)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // The receiver drops ready at random according to the current idle mode.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Every completed result transaction is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_selection(m_selected_index);
    end

    // The run is declared hung when no transaction moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                src_gap_pct = 0;
                sink_stall_pct = 0;
            end
            IDLE_SENDER: begin
                src_gap_pct = 61;
                sink_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                src_gap_pct = 0;
                sink_stall_pct = 61;
            end
            default: begin
                src_gap_pct = 19;
                sink_stall_pct = 19;
            end
        endcase
    endtask

    // Presents one input transaction after a random gap and waits for its acceptance.
    // Valid stays high into the next call when no gap is drawn, so it is never
    // lowered and raised in the same time step.
    task automatic send_item(input logic act, input logic first,
                             input logic [SCORE_W-1:0] score,
                             input logic [RV_W-1:0] rv);
        @(negedge aclk);
        while ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_first <= first;
        s_score <= score;
        s_random_value <= rv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_transaction(act, first, score, rv);
        items_sent++;
    endtask

    // Drains every outstanding selection, then lets a load still in flight finish.
    task automatic wait_block_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_picks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_pop(input logic [POP_W-1:0] value);
        wait_block_idle();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_pop(value);
    endtask

    // Scores mostly stay near 1.0 so the wheel fills without saturating too early.
    function automatic logic [SCORE_W-1:0] pick_score();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 12) return SCORE_TOP;
        if (r < 22) return SCORE_W'($urandom_range(0, SCORE_TOP));
        return SCORE_W'($urandom_range(0, 2 * SCORE_ONE - 1));
    endfunction

    // Draw values aim at the slot boundaries as well as the whole range.
    function automatic logic [RV_W-1:0] pick_draw_value(input int unsigned eff);
        int unsigned     r;
        int unsigned     slot;
        logic [RV_W-1:0] bound;
        r = $urandom_range(99);
        slot = $urandom_range(0, eff - 2);
        bound = sb.wheel[slot];
        if (r < 10) return '0;
        if (r < 20) return RV_TOP;
        if (r < 30) return bound;
        if (r < 38) return (bound == RV_TOP) ? bound : bound + 1'b1;
        if (r < 44) return (bound == '0) ? bound : bound - 1'b1;
        return RV_W'($urandom);
    endfunction

    // One wheel: configure, load every entry (sometimes fewer or more), then draw.
    task automatic run_round(input int unsigned pop_value, input bit overfill);
        int unsigned eff;
        int unsigned n_loads;
        int unsigned n_draws;
        bit          broken;
        write_pop(pop_value[POP_W-1:0]);
        eff = sb.wheel_size();
        broken = ($urandom_range(99) < 12);
        if (broken) n_loads = $urandom_range(1, eff);
        else if (overfill) n_loads = eff + $urandom_range(1, 8);
        else n_loads = eff;
        for (int unsigned k = 0; k < n_loads; k++) begin
            // A broken wheel may also restart midway or continue an older one.
            send_item(ACT_LOAD,
                      (k == 0) ? !(broken && $urandom_range(1)) : ($urandom_range(99) < 2),
                      pick_score(), RV_W'($urandom));
        end
        n_draws = $urandom_range(3, 14);
        for (int unsigned k = 0; k < n_draws; k++) begin
            if (sb.draw_allowed())
                send_item(ACT_DRAW, 1'($urandom_range(1)),
                          SCORE_W'($urandom_range(0, SCORE_TOP)),
                          pick_draw_value(eff));
        end
    endtask

    initial begin
        int unsigned r;
        int unsigned round_idx;
        int unsigned phase;
        sb = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. A population of one acts as two; a full score saturates.
        write_pop(9'd1);
        send_item(ACT_LOAD, 1'b1, SCORE_TOP, '0);
        send_item(ACT_LOAD, 1'b0, '0, RV_TOP);
        send_item(ACT_DRAW, 1'b0, '0, '0);
        send_item(ACT_DRAW, 1'b0, '0, RV_TOP);
        // The flag and the score are ignored on a draw.
        send_item(ACT_DRAW, 1'b1, SCORE_TOP, RV_W'($urandom));
        // An all-zero wheel sends every nonzero draw to the last entry.
        send_item(ACT_LOAD, 1'b1, '0, '0);
        send_item(ACT_LOAD, 1'b0, '0, '0);
        send_item(ACT_DRAW, 1'b0, '0, '0);
        send_item(ACT_DRAW, 1'b0, '0, 31'd1);
        // Three equal entries; draw exactly on and just past the boundaries.
        write_pop(9'd3);
        send_item(ACT_LOAD, 1'b1, SCORE_ONE, '0);
        send_item(ACT_LOAD, 1'b0, SCORE_ONE, '0);
        send_item(ACT_LOAD, 1'b0, SCORE_ONE, '0);
        send_item(ACT_DRAW, 1'b0, '0, sb.wheel[0]);
        send_item(ACT_DRAW, 1'b0, '0, sb.wheel[0] + 1'b1);
        send_item(ACT_DRAW, 1'b0, '0, sb.wheel[1] + 1'b1);

        // Random part, in four idling phases by progress. The first rounds cover the
        // full table with extra loads past its end, then the register extremes.
        round_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            phase = (items_sent * 4) / ITEM_TARGET;
            if (phase > 3) phase = 3;
            set_idle_mode(idle_mode_t'(phase));
            case (round_idx)
                0: run_round(256, 1'b1);
                1: run_round(511, 1'b0);
                2: run_round(0, 1'b0);
                3: run_round(2, 1'b1);
                default: begin
                    r = $urandom_range(99);
                    if (r < 3) run_round(256, $urandom_range(1));
                    else if (r < 8) run_round($urandom_range(257, 511), 1'b0);
                    else if (r < 14) run_round($urandom_range(0, 1), $urandom_range(1));
                    else if (r < 75) run_round($urandom_range(2, 20), $urandom_range(1));
                    else run_round($urandom_range(21, 100), 1'b0);
                end
            endcase
            round_idx++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_picks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_picks.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
